FILE: hw/rtl/pav_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pav_pkg
// Shared types and constants for the piece availability window.
// ============================================================================
package pav_pkg;

    localparam int MAP_SIZE_DEF = 1024;
    localparam int MAX_WORD_W   = 32;

    localparam int REQ_W = 3;
    localparam int ID_W  = 10;
    localparam int RUN_W = 10;
    localparam int CAP_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd64;
    localparam logic [CAP_W-1:0] COUNT_MAX = 11'd2047;
    localparam int               RUN_MAX   = 1023;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PRESENCE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RUN       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COMMIT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_ALL   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RUN,
        ST_ERASE,
        ST_MERGE_PREP,
        ST_MERGE,
        ST_FILL,
        ST_RESULT
    } state_t;

endpackage

FILE: hw/rtl/pav_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// pav_ram
// Simple dual-port bitmap memory, one write and one registered read port.
// ============================================================================
module pav_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/pav_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// pav_seq
// Request sequencer: word-wide read-modify-write walks over both bitmaps.
// ============================================================================
module pav_seq #(
    parameter int MAP_SIZE = pav_pkg::MAP_SIZE_DEF,
    parameter int W        = 32,
    parameter int AW       = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pav_pkg::CAP_W-1:0]   cap,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pav_pkg::REQ_W-1:0]   s_req,
    input  logic [pav_pkg::ID_W-1:0]    s_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_flag,
    output logic [pav_pkg::RUN_W-1:0]   m_run,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [W-1:0]                c_rdata,
    input  logic [W-1:0]                p_rdata,
    output logic                        c_we,
    output logic [AW-1:0]               c_waddr,
    output logic [W-1:0]                c_wdata,
    output logic                        p_we,
    output logic [AW-1:0]               p_waddr,
    output logic [W-1:0]                p_wdata
);

    localparam int NUM_WORDS = (MAP_SIZE + W - 1) / W;
    localparam int LAST_BITS = MAP_SIZE - (NUM_WORDS - 1) * W;
    localparam int BW        = $clog2(W);
    localparam int IDW       = $clog2(MAP_SIZE);
    localparam int PW        = IDW + 1;
    localparam int CW        = IDW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);
    localparam logic [W-1:0]  LAST_MASK = {W{1'b1}} >> (W - LAST_BITS);
    localparam logic [PW-1:0] EP_MAX    = PW'(MAP_SIZE - 1);

    function automatic logic [W-1:0] thermo_le(input logic [BW-1:0] p);
        logic [W-1:0] m;
        for (int i = 0; i < W; i++) begin
            m[i] = (i <= int'(p));
        end
        return m;
    endfunction

    pav_pkg::state_t state_reg, state_next;

    logic [AW-1:0]               addr_reg, addr_next;
    logic [BW-1:0]               pos_reg, pos_next;
    logic                        first_reg, first_next;
    logic [pav_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [pav_pkg::ID_W-1:0]    id_reg, id_next;
    logic                        flag_reg, flag_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic signed [PW-1:0]        ep_reg, ep_next;
    logic [pav_pkg::CAP_W-1:0]   acc_reg, acc_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_flag_reg, out_flag_next;
    logic [pav_pkg::RUN_W-1:0]   out_run_reg, out_run_next;

    logic                        accept;
    logic                        id_in_map;
    logic [pav_pkg::ID_W:0]      run_start;
    logic                        run_ok;
    logic                        ep_neg;
    logic [IDW-1:0]              ep_u;
    logic [AW-1:0]               ep_word;
    logic [BW-1:0]               ep_bit;
    logic [W-1:0]                both;
    logic                        present;
    logic [pav_pkg::CAP_W-1:0]   acc_inc;
    logic [W-1:0]                gt_mask;
    logic [W-1:0]                run_v;
    logic [W-1:0]                run_z;
    logic [W-1:0]                run_iso;
    logic [BW-1:0]               run_low;
    logic [BW-1:0]               er_top;
    logic [W-1:0]                er_mle;
    logic [W-1:0]                er_z;
    logic [W-1:0]                er_smear;
    logic                        er_more;
    logic                        out_free;
    logic [pav_pkg::RUN_W-1:0]   run_sat;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == pav_pkg::ST_IDLE);
    assign id_in_map = (32'(s_id) < 32'(MAP_SIZE));
    assign run_start = {1'b0, s_id} + 1'b1;
    assign run_ok    = id_in_map && (32'(run_start) < 32'(MAP_SIZE));

    assign ep_neg  = ep_reg[PW-1];
    assign ep_u    = ep_reg[PW-2:0];
    assign ep_word = AW'(ep_u >> BW);
    assign ep_bit  = BW'(ep_u);

    assign both    = c_rdata | p_rdata;
    assign present = both[BW'(id_reg)]
                     && (ep_neg || ($signed({1'b0, IDW'(id_reg)}) > ep_reg));
    assign acc_inc = (acc_reg < pav_pkg::COUNT_MAX) ? acc_reg + 1'b1 : acc_reg;

    always_comb begin
        if (ep_neg || (addr_reg > ep_word)) begin
            gt_mask = '1;
        end else if (addr_reg == ep_word) begin
            gt_mask = ~thermo_le(ep_bit);
        end else begin
            gt_mask = '0;
        end
    end

    assign run_v   = both & gt_mask & ((addr_reg == LAST_ADDR) ? LAST_MASK : '1);
    assign run_z   = ~run_v & (~thermo_le(pos_reg) | (W'(1) << pos_reg));
    assign run_iso = run_z & (~run_z + 1'b1);

    always_comb begin
        run_low = '0;
        for (int i = 0; i < W; i++) begin
            if (run_iso[i]) begin
                run_low = run_low | BW'(i);
            end
        end
    end

    // erase walk: clear the run of ones from the top position downward
    assign er_top = first_reg ? ep_bit : BW'(W - 1);
    assign er_mle = thermo_le(er_top);
    assign er_z   = ~c_rdata & er_mle;

    always_comb begin
        er_smear = er_z;
        for (int k = 0; k < BW; k++) begin
            er_smear = er_smear | (er_smear >> (1 << k));
        end
    end

    assign er_more  = (er_z == '0) && (addr_reg != '0);
    assign out_free = !out_valid_reg || m_ready;
    assign run_sat  = (32'(cnt_reg) > 32'(pav_pkg::RUN_MAX)) ?
                      pav_pkg::RUN_W'(pav_pkg::RUN_MAX) : pav_pkg::RUN_W'(cnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pav_pkg::ST_CLEAR: begin
                if (addr_reg == LAST_ADDR) begin
                    state_next = pav_pkg::ST_IDLE;
                end
            end
            pav_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_req) inside
                        pav_pkg::REQ_INSERT, pav_pkg::REQ_PRESENCE: begin
                            state_next = id_in_map ? pav_pkg::ST_LOOKUP : pav_pkg::ST_RESULT;
                        end
                        pav_pkg::REQ_RUN: begin
                            state_next = run_ok ? pav_pkg::ST_RUN : pav_pkg::ST_RESULT;
                        end
                        pav_pkg::REQ_COMMIT: begin
                            state_next = ep_neg ? pav_pkg::ST_MERGE_PREP : pav_pkg::ST_ERASE;
                        end
                        pav_pkg::REQ_SET_ALL, pav_pkg::REQ_CLEAR_ALL: begin
                            state_next = pav_pkg::ST_FILL;
                        end
                        default: begin
                            state_next = pav_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            pav_pkg::ST_LOOKUP: begin
                state_next = pav_pkg::ST_RESULT;
            end
            pav_pkg::ST_RUN: begin
                if ((run_z != '0) || (addr_reg == LAST_ADDR)) begin
                    state_next = pav_pkg::ST_RESULT;
                end
            end
            pav_pkg::ST_ERASE: begin
                if (!er_more) begin
                    state_next = pav_pkg::ST_MERGE_PREP;
                end
            end
            pav_pkg::ST_MERGE_PREP: begin
                state_next = pav_pkg::ST_MERGE;
            end
            pav_pkg::ST_MERGE, pav_pkg::ST_FILL: begin
                if (addr_reg == LAST_ADDR) begin
                    state_next = pav_pkg::ST_RESULT;
                end
            end
            pav_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = pav_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pav_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        req_next       = req_reg;
        id_next        = id_reg;
        flag_next      = flag_reg;
        cnt_next       = cnt_reg;
        ep_next        = ep_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_flag_next  = out_flag_reg;
        out_run_next   = out_run_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        c_we           = 1'b0;
        c_waddr        = addr_reg;
        c_wdata        = '0;
        p_we           = 1'b0;
        p_waddr        = addr_reg;
        p_wdata        = '0;

        unique case (state_reg)
            pav_pkg::ST_CLEAR: begin
                c_we      = 1'b1;
                p_we      = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    addr_next = '0;
                end
            end
            pav_pkg::ST_IDLE: begin
                if (accept) begin
                    req_next   = s_req;
                    id_next    = s_id;
                    flag_next  = 1'b0;
                    cnt_next   = '0;
                    first_next = 1'b1;
                    addr_next  = '0;
                    unique case (s_req) inside
                        pav_pkg::REQ_INSERT, pav_pkg::REQ_PRESENCE: begin
                            rd_en     = id_in_map;
                            rd_addr   = AW'(s_id >> BW);
                            addr_next = AW'(s_id >> BW);
                        end
                        pav_pkg::REQ_RUN: begin
                            rd_en     = run_ok;
                            rd_addr   = AW'(run_start >> BW);
                            addr_next = AW'(run_start >> BW);
                            pos_next  = BW'(run_start);
                        end
                        pav_pkg::REQ_COMMIT: begin
                            rd_en     = !ep_neg;
                            rd_addr   = ep_word;
                            addr_next = ep_word;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pav_pkg::ST_LOOKUP: begin
                if (req_reg == pav_pkg::REQ_INSERT) begin
                    if (!present) begin
                        p_we      = 1'b1;
                        p_wdata   = p_rdata | (W'(1) << BW'(id_reg));
                        flag_next = 1'b1;
                        acc_next  = acc_inc;
                        if ((acc_inc > cap) && (ep_reg != EP_MAX)) begin
                            ep_next = ep_reg + 1'b1;
                        end
                    end
                end else begin
                    flag_next = present;
                end
            end
            pav_pkg::ST_RUN: begin
                if (run_z == '0) begin
                    cnt_next = cnt_reg + CW'(W) - CW'(pos_reg);
                    if (addr_reg != LAST_ADDR) begin
                        rd_en     = 1'b1;
                        rd_addr   = addr_reg + 1'b1;
                        addr_next = addr_reg + 1'b1;
                        pos_next  = '0;
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(run_low) - CW'(pos_reg);
                end
            end
            pav_pkg::ST_ERASE: begin
                c_we    = 1'b1;
                c_wdata = c_rdata & ~(er_mle & ~er_smear);
                if (er_more) begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_reg - 1'b1;
                    addr_next  = addr_reg - 1'b1;
                    first_next = 1'b0;
                end
            end
            pav_pkg::ST_MERGE_PREP: begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                addr_next = '0;
            end
            pav_pkg::ST_MERGE: begin
                c_we    = 1'b1;
                c_wdata = both;
                p_we    = 1'b1;
                if (addr_reg != LAST_ADDR) begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            pav_pkg::ST_FILL: begin
                c_we      = 1'b1;
                c_wdata   = (req_reg == pav_pkg::REQ_SET_ALL) ? '1 : '0;
                addr_next = addr_reg + 1'b1;
            end
            pav_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_flag_next  = flag_reg;
                    out_run_next   = run_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pav_pkg::ST_CLEAR;
            addr_reg      <= '0;
            first_reg     <= 1'b0;
            flag_reg      <= 1'b0;
            cnt_reg       <= '0;
            ep_reg        <= '1;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            first_reg     <= first_next;
            flag_reg      <= flag_next;
            cnt_reg       <= cnt_next;
            ep_reg        <= ep_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        req_reg      <= req_next;
        id_reg       <= id_next;
        out_flag_reg <= out_flag_next;
        out_run_reg  <= out_run_next;
    end

    assign m_valid = out_valid_reg;
    assign m_flag  = out_flag_reg;
    assign m_run   = out_run_reg;

endmodule

FILE: hw/rtl/piece_availability_window.sv
`timescale 1ns / 1ps
// ============================================================================
// piece_availability_window
// Per-peer piece bitmaps (committed and pending) with erase window and runs.
// ============================================================================
//  channel   direction  signals                           content
//  s_        in         s_tvalid s_tready s_tdata s_tuser request
//  m_        out        m_tvalid m_tready m_tdata         result
//  cfg_      in         cfg_valid cfg_ready cfg_data      buffer capacity
//
//  Maps are held in 32-bit words (16-bit below 32 pieces), N = words per map.
//  Insert and presence read one word; a run query walks words until the run or the map ends;
//  commit erases from the window end downward, then merges all N words; set all
//  and clear all write all N words; unused request codes go straight to a result.
//  After reset a clearing pass zeroes both maps; s_tready is low.
//  A result waits in the output register while the next transaction is taken.
// ============================================================================
module piece_availability_window #(
    parameter int MAP_SIZE = pav_pkg::MAP_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // piece_id
    input  logic [pav_pkg::REQ_W-1:0]  s_tuser,   // req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // flag, run_length
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pav_pkg::CAP_W-1:0]  cfg_data
);

    localparam int W         = (MAP_SIZE < pav_pkg::MAX_WORD_W) ? 16 : pav_pkg::MAX_WORD_W;
    localparam int NUM_WORDS = (MAP_SIZE + W - 1) / W;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [pav_pkg::CAP_W-1:0] cap_reg;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [W-1:0]              c_rdata, p_rdata;
    logic                      c_we, p_we;
    logic [AW-1:0]             c_waddr, p_waddr;
    logic [W-1:0]              c_wdata, p_wdata;
    logic                      res_flag;
    logic [pav_pkg::RUN_W-1:0] res_run;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= pav_pkg::CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    pav_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (W),
        .AW    (AW)
    ) u_committed (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (c_rdata)
    );

    pav_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (W),
        .AW    (AW)
    ) u_pending (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (p_rdata)
    );

    pav_seq #(
        .MAP_SIZE (MAP_SIZE),
        .W        (W),
        .AW       (AW)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cap     (cap_reg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_req   (s_tuser),
        .s_id    (s_tdata[pav_pkg::ID_W-1:0]),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_flag  (res_flag),
        .m_run   (res_run),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .c_rdata (c_rdata),
        .p_rdata (p_rdata),
        .c_we    (c_we),
        .c_waddr (c_waddr),
        .c_wdata (c_wdata),
        .p_we    (p_we),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata)
    );

    assign m_tdata = {5'd0, res_run, res_flag};

endmodule
